// File: rtl/rcfs_pkg.sv
`timescale 1ns / 1ps

package rcfs_pkg;

    localparam int SEQUENCE_LENGTH = 9;
    localparam int IDX_W           = 4;
    localparam int LEVEL_W         = 8;
    localparam int TIMER_W         = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [TIMER_W-1:0] FADE_INTERVAL_RESET  = 16'd10;
    localparam logic [LEVEL_W-1:0] FADE_STEP_RESET      = 8'd1;
    localparam logic [TIMER_W-1:0] CYCLE_INTERVAL_RESET = 16'd5000;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_SET_ALL   = 3'd1,
        CMD_SET_RED   = 3'd2,
        CMD_SET_GREEN = 3'd3,
        CMD_SET_BLUE  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_INTERVAL  = 2'd0,
        REG_FADE_STEP      = 2'd1,
        REG_CYCLE_MODE     = 2'd2,
        REG_CYCLE_INTERVAL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } color_t;

    // Timer decisions for the current beat.
    typedef struct packed {
        logic fade_fire;
        logic cycle_load;
    } timer_ctrl_t;

    // Per-channel update controls.
    typedef struct packed {
        logic fade_fire;
        logic cycle_load;
        logic set_target;
        logic recompute;
    } chan_ctrl_t;

    function automatic color_t color_lookup(input logic [IDX_W-1:0] idx);
        color_t c;
        unique case (idx)
            4'd0:    c = '{8'd255, 8'd0,   8'd0};
            4'd1:    c = '{8'd0,   8'd255, 8'd0};
            4'd2:    c = '{8'd0,   8'd0,   8'd255};
            4'd3:    c = '{8'd255, 8'd255, 8'd255};
            4'd4:    c = '{8'd255, 8'd255, 8'd0};
            4'd5:    c = '{8'd255, 8'd0,   8'd255};
            4'd6:    c = '{8'd255, 8'd120, 8'd0};
            4'd7:    c = '{8'd0,   8'd255, 8'd255};
            4'd8:    c = '{8'd255, 8'd255, 8'd255};
            default: c = '{8'd0,   8'd0,   8'd0};
        endcase
        return c;
    endfunction

endpackage

// File: rtl/rcfs_timer.sv
`timescale 1ns / 1ps

module rcfs_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_en,
    input  logic [rcfs_pkg::TIMER_W-1:0]        fade_interval,
    input  logic                                cycle_mode,
    input  logic [rcfs_pkg::TIMER_W-1:0]        cycle_interval,
    output rcfs_pkg::timer_ctrl_t               ctrl,
    output rcfs_pkg::color_t                    color
);

    logic [rcfs_pkg::TIMER_W-1:0] fade_elapsed_reg, fade_elapsed_next;
    logic [rcfs_pkg::TIMER_W-1:0] cycle_elapsed_reg, cycle_elapsed_next;
    logic [rcfs_pkg::IDX_W-1:0]   cycle_index_reg, cycle_index_next;
    logic [rcfs_pkg::TIMER_W-1:0] fade_inc, cycle_inc;
    logic [rcfs_pkg::IDX_W:0]     index_inc;

    always_comb
    begin
        // saturating counts
        fade_inc  = (&fade_elapsed_reg) ? fade_elapsed_reg
                                        : fade_elapsed_reg + rcfs_pkg::TIMER_W'(1);
        cycle_inc = (&cycle_elapsed_reg) ? cycle_elapsed_reg
                                         : cycle_elapsed_reg + rcfs_pkg::TIMER_W'(1);
        index_inc = {1'b0, cycle_index_reg} + (rcfs_pkg::IDX_W+1)'(1);

        ctrl.fade_fire  = tick_en && (fade_inc >= fade_interval);
        ctrl.cycle_load = tick_en && cycle_mode && (cycle_inc >= cycle_interval);
        color           = rcfs_pkg::color_lookup(cycle_index_reg);

        fade_elapsed_next  = fade_elapsed_reg;
        cycle_elapsed_next = cycle_elapsed_reg;
        cycle_index_next   = cycle_index_reg;
        if (tick_en)
        begin
            fade_elapsed_next  = ctrl.fade_fire ? '0 : fade_inc;
            cycle_elapsed_next = ctrl.cycle_load ? '0 : cycle_inc;
        end
        if (ctrl.cycle_load)
        begin
            if (index_inc >= (rcfs_pkg::IDX_W+1)'(rcfs_pkg::SEQUENCE_LENGTH))
                cycle_index_next = '0;
            else
                cycle_index_next = index_inc[rcfs_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_elapsed_reg  <= '0;
            cycle_elapsed_reg <= '0;
            cycle_index_reg   <= '0;
        end
        else
        begin
            fade_elapsed_reg  <= fade_elapsed_next;
            cycle_elapsed_reg <= cycle_elapsed_next;
            cycle_index_reg   <= cycle_index_next;
        end
    end

endmodule

// File: rtl/rcfs_channel.sv
`timescale 1ns / 1ps

module rcfs_channel (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rcfs_pkg::chan_ctrl_t             ctrl,
    input  logic [rcfs_pkg::LEVEL_W-1:0]     set_value,
    input  logic [rcfs_pkg::LEVEL_W-1:0]     color_value,
    input  logic [rcfs_pkg::LEVEL_W-1:0]     fade_step,
    output logic [rcfs_pkg::LEVEL_W-1:0]     level,
    output logic                             moving
);

    typedef enum logic [1:0] {
        DIR_STILL = 2'd0,
        DIR_UP    = 2'd1,
        DIR_DOWN  = 2'd2
    } dir_t;

    logic [rcfs_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [rcfs_pkg::LEVEL_W-1:0] target_reg, target_next;
    dir_t                         dir_reg, dir_next;
    logic [rcfs_pkg::LEVEL_W-1:0] stepped_level;
    dir_t                         stepped_dir;
    logic [rcfs_pkg::LEVEL_W:0]   gap_up, gap_down, step_ext;

    function automatic dir_t compare_dir(input logic [rcfs_pkg::LEVEL_W-1:0] tgt,
                                         input logic [rcfs_pkg::LEVEL_W-1:0] cur);
        dir_t d;
        if (tgt > cur)
            d = DIR_UP;
        else if (tgt < cur)
            d = DIR_DOWN;
        else
            d = DIR_STILL;
        return d;
    endfunction

    always_comb
    begin
        gap_up   = {1'b0, target_reg} - {1'b0, level_reg};
        gap_down = {1'b0, level_reg} - {1'b0, target_reg};
        step_ext = {1'b0, fade_step};

        // fade step, landing on the target instead of passing it
        stepped_level = level_reg;
        stepped_dir   = dir_reg;
        if (ctrl.fade_fire)
        begin
            unique case (dir_reg)
                DIR_UP:
                begin
                    if ((target_reg <= level_reg) || (gap_up <= step_ext))
                    begin
                        stepped_level = target_reg;
                        stepped_dir   = DIR_STILL;
                    end
                    else
                        stepped_level = level_reg + fade_step;
                end
                DIR_DOWN:
                begin
                    if ((level_reg <= target_reg) || (gap_down <= step_ext))
                    begin
                        stepped_level = target_reg;
                        stepped_dir   = DIR_STILL;
                    end
                    else
                        stepped_level = level_reg - fade_step;
                end
                default: ;
            endcase
        end

        level_next  = stepped_level;
        target_next = target_reg;
        dir_next    = stepped_dir;
        if (ctrl.cycle_load)
        begin
            target_next = color_value;
            dir_next    = compare_dir(color_value, stepped_level);
        end
        else if (ctrl.recompute)
        begin
            target_next = ctrl.set_target ? set_value : target_reg;
            dir_next    = compare_dir(target_next, level_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            target_reg <= '0;
            dir_reg    <= DIR_STILL;
        end
        else
        begin
            level_reg  <= level_next;
            target_reg <= target_next;
            dir_reg    <= dir_next;
        end
    end

    assign level  = level_reg;
    assign moving = (dir_reg != DIR_STILL);

endmodule

// File: rtl/rgb_color_fade_sequencer_top.sv
`timescale 1ns / 1ps

// Three-channel LED level fader with automatic colour cycling.
//
// Input channel (in_valid/in_ready): one beat carries a command and three
// values. Command tick advances the fade and cycle timers by one ms; the
// set commands load all three targets or a single one.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// carrying the three levels and the fading flag after that command.
//
// An input beat is captured into the input register, then moves into the
// channel state registers, from which its result is presented.
// Throughput is one beat per cycle while out_ready stays high: the state
// update is one short add/compare per channel plus the saturating timers.
//
// Stall: while a result waits on out_ready, one more input beat is held
// in the input register; in_ready drops only when both are occupied.
// Reset (rst_n low, async) clears levels, targets, timers and cycle index
// and restores the register defaults. Config writes (cfg_we) take effect
// at once and are meant for idle periods.
module rgb_color_fade_sequencer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rcfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          command,
    input  logic [7:0]                          red_value,
    input  logic [7:0]                          green_value,
    input  logic [7:0]                          blue_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          red_level,
    output logic [7:0]                          green_level,
    output logic [7:0]                          blue_level,
    output logic                                fading
);

    // configuration registers
    logic [rcfs_pkg::TIMER_W-1:0] fade_interval_reg;
    logic [rcfs_pkg::LEVEL_W-1:0] fade_step_reg;
    logic                         cycle_mode_reg;
    logic [rcfs_pkg::TIMER_W-1:0] cycle_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_interval_reg  <= rcfs_pkg::FADE_INTERVAL_RESET;
            fade_step_reg      <= rcfs_pkg::FADE_STEP_RESET;
            cycle_mode_reg     <= 1'b0;
            cycle_interval_reg <= rcfs_pkg::CYCLE_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rcfs_pkg::reg_idx_t'(cfg_index))
                rcfs_pkg::REG_FADE_INTERVAL:  fade_interval_reg  <= cfg_data;
                rcfs_pkg::REG_FADE_STEP:      fade_step_reg      <= cfg_data[7:0];
                rcfs_pkg::REG_CYCLE_MODE:     cycle_mode_reg     <= cfg_data[0];
                rcfs_pkg::REG_CYCLE_INTERVAL: cycle_interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        out_valid_reg;
    logic        advance;

    // the held beat moves into the state when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            red_reg   <= red_value;
            green_reg <= green_value;
            blue_reg  <= blue_value;
        end
    end

    // command decode; unknown codes leave the state untouched
    logic tick_en, set_any, set_red, set_green, set_blue;

    always_comb
    begin
        tick_en   = 1'b0;
        set_any   = 1'b0;
        set_red   = 1'b0;
        set_green = 1'b0;
        set_blue  = 1'b0;
        if (advance)
        begin
            unique case (rcfs_pkg::cmd_t'(cmd_reg))
                rcfs_pkg::CMD_TICK:      tick_en = 1'b1;
                rcfs_pkg::CMD_SET_ALL:
                begin
                    set_any   = 1'b1;
                    set_red   = 1'b1;
                    set_green = 1'b1;
                    set_blue  = 1'b1;
                end
                rcfs_pkg::CMD_SET_RED:
                begin
                    set_any = 1'b1;
                    set_red = 1'b1;
                end
                rcfs_pkg::CMD_SET_GREEN:
                begin
                    set_any   = 1'b1;
                    set_green = 1'b1;
                end
                rcfs_pkg::CMD_SET_BLUE:
                begin
                    set_any  = 1'b1;
                    set_blue = 1'b1;
                end
                default: ;
            endcase
        end
    end

    rcfs_pkg::timer_ctrl_t timer_ctrl;
    rcfs_pkg::color_t      color;

    rcfs_timer u_timer (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_en        (tick_en),
        .fade_interval  (fade_interval_reg),
        .cycle_mode     (cycle_mode_reg),
        .cycle_interval (cycle_interval_reg),
        .ctrl           (timer_ctrl),
        .color          (color)
    );

    rcfs_pkg::chan_ctrl_t red_ctrl, green_ctrl, blue_ctrl;
    logic red_moving, green_moving, blue_moving;

    assign red_ctrl   = '{timer_ctrl.fade_fire, timer_ctrl.cycle_load, set_red,   set_any};
    assign green_ctrl = '{timer_ctrl.fade_fire, timer_ctrl.cycle_load, set_green, set_any};
    assign blue_ctrl  = '{timer_ctrl.fade_fire, timer_ctrl.cycle_load, set_blue,  set_any};

    rcfs_channel u_red (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (red_ctrl),
        .set_value   (red_reg),
        .color_value (color.red),
        .fade_step   (fade_step_reg),
        .level       (red_level),
        .moving      (red_moving)
    );

    rcfs_channel u_green (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (green_ctrl),
        .set_value   (green_reg),
        .color_value (color.green),
        .fade_step   (fade_step_reg),
        .level       (green_level),
        .moving      (green_moving)
    );

    rcfs_channel u_blue (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (blue_ctrl),
        .set_value   (blue_reg),
        .color_value (color.blue),
        .fade_step   (fade_step_reg),
        .level       (blue_level),
        .moving      (blue_moving)
    );

    // the channel state registers double as the result register
    assign out_valid = out_valid_reg;
    assign fading    = red_moving || green_moving || blue_moving;

    // assertions
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input not ready while result slot empty");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat produced no result");

    a_held_beat_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(cmd_reg)))
        else $error("held input beat lost or changed");

    a_no_load_in_manual: assert property (@(posedge clk) disable iff (!rst_n)
        !cycle_mode_reg |-> !timer_ctrl.cycle_load)
        else $error("table colour loaded in manual mode");

endmodule

// File: tb/tb_rgb_color_fade_sequencer_top.sv
`timescale 1ns / 1ps

module tb_rgb_color_fade_sequencer_top;

    import rcfs_pkg::*;

    // Command codes that the block ignores (the field has room for them).
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // Idle draw selectors for the two channels.
    localparam int SENDER   = 0;
    localparam int RECEIVER = 1;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 500;

    // Per-channel motion as fixed when a target is loaded.
    typedef enum logic [1:0] {
        MOVE_STILL = 2'd0,
        MOVE_UP    = 2'd1,
        MOVE_DOWN  = 2'd2
    } move_t;

    // One output beat: the three levels plus the fading flag.
    typedef struct packed {
        color_t levels;
        logic   fading;
    } led_state_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            command = '0;
    logic [7:0]            red_value = '0;
    logic [7:0]            green_value = '0;
    logic [7:0]            blue_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            red_level;
    logic [7:0]            green_level;
    logic [7:0]            blue_level;
    logic                  fading;

    rgb_color_fade_sequencer_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .red_value   (red_value),
        .green_value (green_value),
        .blue_value  (blue_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .fading      (fading)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fader predictor: levels, targets, motion, both ms counters and the
    // palette position, plus a shadow of the four registers.
    // ------------------------------------------------------------------
    logic [7:0]  chan_level  [3];
    logic [7:0]  chan_target [3];
    move_t       chan_move   [3];
    logic [15:0] fade_ticks;
    logic [15:0] cycle_ticks;
    logic [3:0]  palette_pos;

    logic [15:0] fade_interval;
    logic [7:0]  step_size;
    logic        auto_cycle;
    logic [15:0] cycle_interval;

    led_state_t expected_levels[$];

    int mismatch_count = 0;

    function automatic void clear_fader();
        for (int ch = 0; ch < 3; ch++)
        begin
            chan_level[ch]  = '0;
            chan_target[ch] = '0;
            chan_move[ch]   = MOVE_STILL;
        end
        fade_ticks     = '0;
        cycle_ticks    = '0;
        palette_pos    = '0;
        fade_interval  = FADE_INTERVAL_RESET;
        step_size      = FADE_STEP_RESET;
        auto_cycle     = 1'b0;
        cycle_interval = CYCLE_INTERVAL_RESET;
    endfunction

    // Fixed color sequence; slots past the ninth are black.
    function automatic color_t palette(input logic [3:0] pos);
        color_t c;
        case (pos)
            4'd0:    c = 24'hFF_00_00;
            4'd1:    c = 24'h00_FF_00;
            4'd2:    c = 24'h00_00_FF;
            4'd3:    c = 24'hFF_FF_FF;
            4'd4:    c = 24'hFF_FF_00;
            4'd5:    c = 24'hFF_00_FF;
            4'd6:    c = 24'hFF_78_00;
            4'd7:    c = 24'h00_FF_FF;
            4'd8:    c = 24'hFF_FF_FF;
            default: c = 24'h00_00_00;
        endcase
        return c;
    endfunction

    // New targets; motion is decided against the levels as they stand now.
    function automatic void aim_channels(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        chan_target[0] = r;
        chan_target[1] = g;
        chan_target[2] = b;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (chan_target[ch] > chan_level[ch])
                chan_move[ch] = MOVE_UP;
            else if (chan_target[ch] < chan_level[ch])
                chan_move[ch] = MOVE_DOWN;
            else
                chan_move[ch] = MOVE_STILL;
        end
    endfunction

    // One fade step; a step that would reach or pass the target lands on it.
    function automatic void step_channels();
        int lv;
        int tg;
        for (int ch = 0; ch < 3; ch++)
        begin
            lv = int'(chan_level[ch]);
            tg = int'(chan_target[ch]);
            if (chan_move[ch] == MOVE_UP)
            begin
                if (tg <= lv || tg - lv <= int'(step_size))
                begin
                    chan_level[ch] = chan_target[ch];
                    chan_move[ch]  = MOVE_STILL;
                end
                else
                    chan_level[ch] = chan_level[ch] + step_size;
            end
            else if (chan_move[ch] == MOVE_DOWN)
            begin
                if (lv <= tg || lv - tg <= int'(step_size))
                begin
                    chan_level[ch] = chan_target[ch];
                    chan_move[ch]  = MOVE_STILL;
                end
                else
                    chan_level[ch] = chan_level[ch] - step_size;
            end
        end
    endfunction

    // One ms tick: fade counter first, then the color sequence counter.
    function automatic void advance_ms();
        color_t c;
        int     next_pos;
        if (fade_ticks != 16'hFFFF)
            fade_ticks = fade_ticks + 16'd1;
        if (fade_ticks >= fade_interval)
        begin
            step_channels();
            fade_ticks = '0;
        end
        if (cycle_ticks != 16'hFFFF)
            cycle_ticks = cycle_ticks + 16'd1;
        if (auto_cycle && cycle_ticks >= cycle_interval)
        begin
            c = palette(palette_pos);
            aim_channels(c.red, c.green, c.blue);
            next_pos = int'(palette_pos) + 1;
            if (next_pos >= SEQUENCE_LENGTH)
                next_pos = 0;
            palette_pos = next_pos[3:0];
            cycle_ticks = '0;
        end
    endfunction

    function automatic led_state_t predict_beat(input logic [2:0] cmd,
                                                input logic [7:0] r,
                                                input logic [7:0] g,
                                                input logic [7:0] b);
        led_state_t s;
        case (cmd)
            CMD_TICK:      advance_ms();
            CMD_SET_ALL:   aim_channels(r, g, b);
            CMD_SET_RED:   aim_channels(r, chan_target[1], chan_target[2]);
            CMD_SET_GREEN: aim_channels(chan_target[0], g, chan_target[2]);
            CMD_SET_BLUE:  aim_channels(chan_target[0], chan_target[1], b);
            default:       ;
        endcase
        s.levels.red   = chan_level[0];
        s.levels.green = chan_level[1];
        s.levels.blue  = chan_level[2];
        s.fading       = (chan_move[0] != MOVE_STILL) || (chan_move[1] != MOVE_STILL) ||
                         (chan_move[2] != MOVE_STILL);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Idle pacing. Each side runs in stretches: either calm (no gaps at
    // all) or busy (a random idle gap before each beat). no_gaps forces calm.
    // ------------------------------------------------------------------
    int calm_left [2] = '{0, 0};
    bit calm_run  [2] = '{1'b0, 1'b0};
    bit no_gaps = 1'b0;

    function int draw_wait(input int side);
        if (calm_left[side] == 0)
        begin
            calm_run[side]  = ($urandom_range(0, 3) == 0);
            calm_left[side] = $urandom_range(16, 96);
        end
        calm_left[side] = calm_left[side] - 1;
        if (no_gaps || calm_run[side])
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            default: return 16'($urandom_range(2, 12));
        endcase
    endfunction

    task report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // ------------------------------------------------------------------
    // Drivers. All called from the sequencer at a rising edge.
    // ------------------------------------------------------------------

    // One input beat. valid stays up between back-to-back beats; it only
    // drops when a gap is drawn, so no step sees two writes to it.
    task automatic send_beat(input logic [2:0] cmd, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = draw_wait(SENDER);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        red_value   <= r;
        green_value <= g;
        blue_value  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        expected_levels.push_back(predict_beat(cmd, r, g, b));
    endtask

    // Stop sending and let every outstanding result drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_FADE_INTERVAL:  fade_interval  = data;
            REG_FADE_STEP:      step_size      = data[7:0];
            REG_CYCLE_MODE:     auto_cycle     = data[0];
            REG_CYCLE_INTERVAL: cycle_interval = data;
            default:            ;
        endcase
    endtask

    // Writes all four registers back to back; only call once settled.
    task automatic configure(input logic [15:0] fade_ms, input logic [7:0] step_lvl,
                             input logic mode, input logic [15:0] cycle_ms);
        write_reg(REG_FADE_INTERVAL, fade_ms);
        write_reg(REG_FADE_STEP, {8'h00, step_lvl});
        write_reg(REG_CYCLE_MODE, {15'h0000, mode});
        write_reg(REG_CYCLE_INTERVAL, cycle_ms);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: 10 ms per step of 1. Unused commands must leave
    // everything alone.
    task automatic test_default_fade();
        send_beat(CMD_SET_ALL, 8'hFF, 8'h00, 8'hAA);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_beat(c[2:0], 8'hFF, 8'hFF, 8'hFF);
        repeat (11) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_SET_GREEN, 8'h00, 8'h01, 8'h00);
        send_beat(CMD_TICK, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // Step clamping at the target, zero step, zero fade interval.
    task automatic test_step_limits();
        settle();
        configure(16'd0, 8'd255, 1'b0, CYCLE_INTERVAL_RESET);
        send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_SET_RED, 8'h01, 8'h00, 8'h00);
        send_beat(CMD_SET_GREEN, 8'h00, 8'hFF, 8'h00);
        send_beat(CMD_SET_BLUE, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);

        // zero step: channels keep moving but never change
        settle();
        configure(16'd0, 8'd0, 1'b0, CYCLE_INTERVAL_RESET);
        send_beat(CMD_SET_ALL, 8'h80, 8'h80, 8'h80);
        repeat (3) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);

        // odd step, last step short of a full one
        settle();
        configure(16'd1, 8'd7, 1'b0, 16'd0);
        repeat (24) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_SET_ALL, 8'h00, 8'hFF, 8'h02);
        repeat (24) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
    endtask

    // Auto color sequencing: zero interval loads a color every tick and
    // the table wraps; set commands still land in between.
    task automatic test_color_cycle();
        settle();
        configure(16'd0, 8'd255, 1'b1, 16'd0);
        repeat (20) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_SET_ALL, 8'h12, 8'h34, 8'h56);
        send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);

        settle();
        configure(16'd2, 8'd64, 1'b1, 16'd3);
        repeat (40) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
    endtask

    // Longest intervals: no fade fires within a short run, and the cycle
    // counter keeps counting in manual mode, so entering cycle mode with
    // an interval already passed loads a color on the very next tick.
    task automatic test_long_intervals();
        settle();
        configure(16'hFFFF, 8'd1, 1'b0, 16'hFFFF);
        no_gaps = 1'b1;
        send_beat(CMD_SET_ALL, 8'h28, 8'hC8, 8'h00);
        repeat (20) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
        settle();
        configure(16'd0, 8'd255, 1'b1, 16'd16);
        repeat (4) send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00);
        no_gaps = 1'b0;
    endtask

    // Random phases: fresh register settings, then a command mix weighted
    // toward ticks so fades and color loads actually run.
    task automatic test_random_traffic();
        logic [2:0] cmd;
        int         roll;
        for (int phase = 0; phase < 12; phase++)
        begin
            settle();
            roll = $urandom_range(0, 9);
            configure(pick_interval(),
                      (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 :
                      (roll < 5) ? 8'd1 : 8'($urandom_range(1, 64)),
                      1'($urandom_range(0, 1)), pick_interval());
            repeat (135)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    cmd = CMD_TICK;
                else if (roll < 70)
                    cmd = CMD_SET_ALL;
                else if (roll < 90)
                    cmd = 3'($urandom_range(CMD_SET_RED, CMD_SET_BLUE));
                else
                    cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                send_beat(cmd, pick_level(), pick_level(), pick_level());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random out_ready pacing and the per-beat compare.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = draw_wait(RECEIVER);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    led_state_t want_beat;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_levels.size() == 0)
                report_mismatch("result beat with nothing pending", 1, 0);
            else
            begin
                want_beat = expected_levels.pop_front();
                if (red_level !== want_beat.levels.red)
                    report_mismatch("red_level", red_level, want_beat.levels.red);
                if (green_level !== want_beat.levels.green)
                    report_mismatch("green_level", green_level, want_beat.levels.green);
                if (blue_level !== want_beat.levels.blue)
                    report_mismatch("blue_level", blue_level, want_beat.levels.blue);
                if (fading !== want_beat.fading)
                    report_mismatch("fading", fading, want_beat.fading);
            end
        end
    end

    // Hang detector: any accepted beat on either side restarts the count.
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        clear_fader();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_default_fade();
        test_step_limits();
        test_color_cycle();
        test_long_intervals();
        test_random_traffic();

        settle();
        repeat (8) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch("result beats never delivered", 0, expected_levels.size());

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
